/* rtl/dcps_pkg.sv */
// ---------------------------------------------------------------------------
// dcps_pkg
// Shared types and codes for the two-channel pulse sequencer.
// ---------------------------------------------------------------------------
package dcps_pkg;

   localparam int DURATION_W = 32;
   localparam int POSITION_W = 7;
   localparam int ACTION_W   = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACTION_TICK   = 3'd0,
      ACTION_CLEAR  = 3'd1,
      ACTION_APPEND = 3'd2,
      ACTION_START  = 3'd3,
      ACTION_TOGGLE = 3'd4
   } action_type;

   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic                  channel;
      logic                  step_level;
      logic [DURATION_W-1:0] step_duration;
   } req_type;

   typedef struct packed {
      logic                  pin_first;
      logic                  pin_second;
      logic                  busy_first;
      logic                  busy_second;
      logic [POSITION_W-1:0] position_first;
      logic [POSITION_W-1:0] position_second;
      logic                  append_dropped;
   } rsp_type;

   typedef struct packed {
      logic                  level;
      logic [DURATION_W-1:0] duration;
   } step_type;

endpackage

/* rtl/dual_channel_pulse_sequencer.sv */
// ---------------------------------------------------------------------------
// dual_channel_pulse_sequencer
// Two-channel pulse pattern player with per-channel step lists.
// ---------------------------------------------------------------------------
//   channel   direction   payload    handshake
//   req_      in          req_type   req_valid / req_ready
//   rsp_      out         rsp_type   rsp_valid / rsp_ready
//
// One transaction per clock while req_ready is high; each request gives one
// response in the next cycle. The next step of every channel is prefetched
// from its step memory, so an advancing tick needs only the registered data.
// Reset clears lengths, indexes, counters, playback and pins; step memories
// are not cleared.
// req_ready drops only while a response is held and rsp_ready is low.
// ---------------------------------------------------------------------------
module dual_channel_pulse_sequencer #(
   parameter int MAX_STEPS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dcps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dcps_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(MAX_STEPS + 1);
   localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int XW = (IW > dcps_pkg::POSITION_W) ? IW : dcps_pkg::POSITION_W;
   localparam int DW = dcps_pkg::DURATION_W;

   dcps_pkg::step_type steps_first_ff  [MAX_STEPS];
   dcps_pkg::step_type steps_second_ff [MAX_STEPS];

   logic [IW-1:0]      length_ff  [2];
   logic [IW-1:0]      length_in  [2];
   logic [IW-1:0]      index_ff   [2];
   logic [IW-1:0]      index_in   [2];
   logic [DW-1:0]      elapsed_ff [2];
   logic [DW-1:0]      elapsed_in [2];
   logic [DW-1:0]      cur_dur_ff [2];
   logic [DW-1:0]      cur_dur_in [2];
   logic               active_ff  [2];
   logic               active_in  [2];
   logic               level_ff   [2];
   logic               level_in   [2];
   dcps_pkg::step_type head_ff    [2];
   dcps_pkg::step_type head_in    [2];
   dcps_pkg::step_type next_ff    [2];

   logic               wr_en   [2];
   logic [AW-1:0]      wr_addr [2];
   logic [AW-1:0]      rd_addr [2];
   logic [IW-1:0]      rd_idx  [2];
   logic [IW-1:0]      idx_inc [2];
   logic [DW-1:0]      el_sat  [2];
   logic [XW-1:0]      pos_ext [2];
   dcps_pkg::step_type wr_step;

   logic               dropped;
   logic               accept;
   logic               rsp_valid_ff;
   dcps_pkg::rsp_type  rsp_data_ff;
   dcps_pkg::rsp_type  rsp_data_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign wr_step = '{level: req_data.step_level, duration: req_data.step_duration};

   always_comb begin
      dropped = 1'b0;
      for (int ch = 0; ch < 2; ch++) begin
         length_in[ch]  = length_ff[ch];
         index_in[ch]   = index_ff[ch];
         elapsed_in[ch] = elapsed_ff[ch];
         cur_dur_in[ch] = cur_dur_ff[ch];
         active_in[ch]  = active_ff[ch];
         level_in[ch]   = level_ff[ch];
         head_in[ch]    = head_ff[ch];
         wr_en[ch]      = 1'b0;
         wr_addr[ch]    = length_ff[ch][AW-1:0];
         idx_inc[ch]    = index_ff[ch] + IW'(1);
         el_sat[ch]     = (elapsed_ff[ch] == {DW{1'b1}}) ? elapsed_ff[ch]
                                                         : elapsed_ff[ch] + DW'(1);
         if (accept) begin
            unique case (req_data.action)
               dcps_pkg::ACTION_TICK: begin
                  if (active_ff[ch]) begin
                     if (index_ff[ch] >= length_ff[ch]) begin
                        active_in[ch] = 1'b0;
                        level_in[ch]  = 1'b0;
                     end else if (el_sat[ch] >= cur_dur_ff[ch]) begin
                        index_in[ch]   = idx_inc[ch];
                        elapsed_in[ch] = '0;
                        if (idx_inc[ch] < length_ff[ch]) begin
                           level_in[ch]   = next_ff[ch].level;
                           cur_dur_in[ch] = next_ff[ch].duration;
                        end else begin
                           level_in[ch]  = 1'b0;
                           active_in[ch] = 1'b0;
                        end
                     end else begin
                        elapsed_in[ch] = el_sat[ch];
                     end
                  end
               end
               dcps_pkg::ACTION_CLEAR: begin
                  active_in[ch] = 1'b0;
                  if (req_data.channel == 1'(ch)) begin
                     length_in[ch] = '0;
                  end
               end
               dcps_pkg::ACTION_APPEND: begin
                  active_in[ch] = 1'b0;
                  if (req_data.channel == 1'(ch)) begin
                     if (length_ff[ch] < IW'(MAX_STEPS)) begin
                        wr_en[ch]     = 1'b1;
                        length_in[ch] = length_ff[ch] + IW'(1);
                        if (length_ff[ch] == '0) begin
                           head_in[ch] = wr_step;
                        end
                     end else begin
                        dropped = 1'b1;
                     end
                  end
               end
               dcps_pkg::ACTION_START: begin
                  if (length_ff[ch] != '0) begin
                     index_in[ch]   = '0;
                     elapsed_in[ch] = '0;
                     level_in[ch]   = head_ff[ch].level;
                     cur_dur_in[ch] = head_ff[ch].duration;
                     active_in[ch]  = 1'b1;
                  end
               end
               dcps_pkg::ACTION_TOGGLE: begin
                  if (req_data.channel == 1'(ch)) begin
                     level_in[ch] = !level_ff[ch];
                  end
               end
               default: begin
               end
            endcase
         end
         rd_idx[ch]  = index_in[ch] + IW'(1);
         rd_addr[ch] = rd_idx[ch][AW-1:0];
         pos_ext[ch] = XW'(index_in[ch]);
      end
   end

   always_comb begin
      rsp_data_in.pin_first       = level_in[0];
      rsp_data_in.pin_second      = level_in[1];
      rsp_data_in.busy_first      = active_in[0];
      rsp_data_in.busy_second     = active_in[1];
      rsp_data_in.position_first  = pos_ext[0][dcps_pkg::POSITION_W-1:0];
      rsp_data_in.position_second = pos_ext[1][dcps_pkg::POSITION_W-1:0];
      rsp_data_in.append_dropped  = dropped;
   end

   // step memories, registered prefetch of the step after the current one
   always_ff @(posedge clock) begin
      if (wr_en[0]) begin
         steps_first_ff[wr_addr[0]] <= wr_step;
      end
      if (wr_en[1]) begin
         steps_second_ff[wr_addr[1]] <= wr_step;
      end
      next_ff[0] <= steps_first_ff[rd_addr[0]];
      next_ff[1] <= steps_second_ff[rd_addr[1]];
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 2; ch++) begin
         cur_dur_ff[ch] <= cur_dur_in[ch];
         head_ff[ch]    <= head_in[ch];
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int ch = 0; ch < 2; ch++) begin
            length_ff[ch]  <= '0;
            index_ff[ch]   <= '0;
            elapsed_ff[ch] <= '0;
            active_ff[ch]  <= 1'b0;
            level_ff[ch]   <= 1'b0;
         end
      end else begin
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         for (int ch = 0; ch < 2; ch++) begin
            length_ff[ch]  <= length_in[ch];
            index_ff[ch]   <= index_in[ch];
            elapsed_ff[ch] <= elapsed_in[ch];
            active_ff[ch]  <= active_in[ch];
            level_ff[ch]   <= level_in[ch];
         end
      end
   end

endmodule

/* tb/sv/dual_channel_pulse_sequencer_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dual_channel_pulse_sequencer_tb
// Self-checking bench for the two-channel pulse sequencer. Directed tests
// cover idle actions, playback with extreme durations, toggles and full
// step lists. Random step programs, noise and random idle and backpressure
// on both channels follow. A behavioral copy of both channels predicts every
// response, and each response is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module dual_channel_pulse_sequencer_tb;

   localparam int MAX_STEPS    = 64;
   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam logic [dcps_pkg::ACTION_W-1:0] ACTION_SPARE_FIRST = 3'd5;
   localparam logic [dcps_pkg::ACTION_W-1:0] ACTION_SPARE_LAST  = 3'd7;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   dcps_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   dcps_pkg::rsp_type rsp_data;

   // per-channel copy of the step lists and playback state
   bit                            step_level_mem [2][MAX_STEPS];
   bit [dcps_pkg::DURATION_W-1:0] step_dur_mem [2][MAX_STEPS];
   int unsigned                   list_length [2];
   int unsigned                   step_index [2];
   bit [dcps_pkg::DURATION_W-1:0] elapsed_ticks [2];
   bit                            playing [2];
   bit                            pin_level [2];

   dcps_pkg::rsp_type expected_rsp_q [$];
   int      error_count   = 0;
   int      counted_items = 0;
   int      cycle_count   = 0;
   int      gap_mode      = 0;
   int      stall_mode    = 0;
   int      stall_left    = 0;

   dual_channel_pulse_sequencer #(.MAX_STEPS(MAX_STEPS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void advance_channel(int ch);
      if (!playing[ch]) return;
      if (step_index[ch] >= list_length[ch]) begin
         playing[ch]   = 1'b0;
         pin_level[ch] = 1'b0;
         return;
      end
      if (elapsed_ticks[ch] != '1) elapsed_ticks[ch]++;
      if (elapsed_ticks[ch] >= step_dur_mem[ch][step_index[ch]]) begin
         step_index[ch]++;
         elapsed_ticks[ch] = '0;
         if (step_index[ch] < list_length[ch]) begin
            pin_level[ch] = step_level_mem[ch][step_index[ch]];
         end else begin
            pin_level[ch] = 1'b0;
            playing[ch]   = 1'b0;
         end
      end
   endfunction

   function automatic dcps_pkg::rsp_type predict_response(dcps_pkg::req_type r);
      dcps_pkg::rsp_type p;
      int      ch;
      ch = int'(r.channel);
      p  = '0;
      case (r.action)
         dcps_pkg::ACTION_TICK: begin
            advance_channel(0);
            advance_channel(1);
         end
         dcps_pkg::ACTION_CLEAR: begin
            playing[0]      = 1'b0;
            playing[1]      = 1'b0;
            list_length[ch] = 0;
         end
         dcps_pkg::ACTION_APPEND: begin
            playing[0] = 1'b0;
            playing[1] = 1'b0;
            if (list_length[ch] < MAX_STEPS) begin
               step_level_mem[ch][list_length[ch]] = r.step_level;
               step_dur_mem[ch][list_length[ch]]   = r.step_duration;
               list_length[ch]++;
            end else begin
               p.append_dropped = 1'b1;
            end
         end
         dcps_pkg::ACTION_START: begin
            for (int c = 0; c < 2; c++) begin
               if (list_length[c] != 0) begin
                  step_index[c]    = 0;
                  elapsed_ticks[c] = '0;
                  pin_level[c]     = step_level_mem[c][0];
                  playing[c]       = 1'b1;
               end
            end
         end
         dcps_pkg::ACTION_TOGGLE: pin_level[ch] = ~pin_level[ch];
         default: ;
      endcase
      p.pin_first       = pin_level[0];
      p.pin_second      = pin_level[1];
      p.busy_first      = playing[0];
      p.busy_second     = playing[1];
      p.position_first  = dcps_pkg::POSITION_W'(step_index[0]);
      p.position_second = dcps_pkg::POSITION_W'(step_index[1]);
      return p;
   endfunction

   function automatic dcps_pkg::req_type make_item(logic [dcps_pkg::ACTION_W-1:0] action,
                                                   int ch, bit lvl,
                                                   bit [dcps_pkg::DURATION_W-1:0] dur);
      dcps_pkg::req_type r;
      r.action        = action;
      r.channel       = ch[0];
      r.step_level    = lvl;
      r.step_duration = dur;
      return r;
   endfunction

   function automatic bit [dcps_pkg::DURATION_W-1:0] random_duration();
      int r;
      r = $urandom_range(99, 0);
      if (r < 6) return $urandom;
      if (r < 9) return '1;
      return $urandom_range(4, 0);
   endfunction

   task automatic send_item(input dcps_pkg::req_type item);
      int gap;
      int r;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(predict_response(item));
      if (item.action <= dcps_pkg::ACTION_TOGGLE) counted_items++;
      gap = 0;
      if (gap_mode != 0) begin
         r = $urandom_range(99, 0);
         if (r >= 95) gap = $urandom_range(30, 8);
         else if (r >= 65) gap = $urandom_range(3, 1);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            error_count++;
            $display("%0t: response with none expected, expected none actual %h",
                     $time, rsp_data);
         end else begin
            dcps_pkg::rsp_type want;
            want = expected_rsp_q.pop_front();
            check_field("pin_first", want.pin_first, rsp_data.pin_first);
            check_field("pin_second", want.pin_second, rsp_data.pin_second);
            check_field("busy_first", want.busy_first, rsp_data.busy_first);
            check_field("busy_second", want.busy_second, rsp_data.busy_second);
            check_field("position_first", want.position_first, rsp_data.position_first);
            check_field("position_second", want.position_second, rsp_data.position_second);
            check_field("append_dropped", want.append_dropped, rsp_data.append_dropped);
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (stall_mode == 0 || $urandom_range(99, 0) < 75) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10)
                                                   : $urandom_range(2, 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_idle_actions();
      gap_mode   = 0;
      stall_mode = 0;
      send_item(make_item(dcps_pkg::ACTION_TICK, 0, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_TICK, 1, 1'b1, '1));
      send_item(make_item(dcps_pkg::ACTION_START, 0, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_TOGGLE, 0, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_TOGGLE, 1, 1'b1, '1));
      send_item(make_item(dcps_pkg::ACTION_TOGGLE, 0, 1'b1, '0));
      for (int a = int'(ACTION_SPARE_FIRST); a <= int'(ACTION_SPARE_LAST); a++) begin
         send_item(make_item(a[dcps_pkg::ACTION_W-1:0], $urandom_range(1, 0),
                             1'($urandom_range(1, 0)), $urandom));
      end
      send_item(make_item(dcps_pkg::ACTION_CLEAR, 0, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_CLEAR, 1, 1'b0, '0));
   endtask

   task automatic test_directed_playback();
      gap_mode   = 1;
      stall_mode = 1;
      send_item(make_item(dcps_pkg::ACTION_APPEND, 0, 1'b1, '0));
      send_item(make_item(dcps_pkg::ACTION_APPEND, 0, 1'b0, 32'd2));
      send_item(make_item(dcps_pkg::ACTION_APPEND, 0, 1'b1, '1));
      send_item(make_item(dcps_pkg::ACTION_APPEND, 1, 1'b0, 32'd1));
      send_item(make_item(dcps_pkg::ACTION_APPEND, 1, 1'b1, 32'h8000_0000));
      send_item(make_item(dcps_pkg::ACTION_START, 0, 1'b0, '0));
      repeat (3) send_item(make_item(dcps_pkg::ACTION_TICK, 0, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_TOGGLE, 0, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_TICK, 0, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_TOGGLE, 1, 1'b0, '0));
      repeat (2) send_item(make_item(dcps_pkg::ACTION_TICK, 1, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_START, 0, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_TICK, 0, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_CLEAR, 1, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_START, 0, 1'b0, '0));
      send_item(make_item(dcps_pkg::ACTION_APPEND, 1, 1'b1, '1));
   endtask

   task automatic test_full_list();
      for (int ch = 0; ch < 2; ch++) begin
         gap_mode   = ch;
         stall_mode = ch;
         send_item(make_item(dcps_pkg::ACTION_CLEAR, ch, 1'b0, '0));
         repeat (MAX_STEPS) begin
            send_item(make_item(dcps_pkg::ACTION_APPEND, ch, 1'($urandom_range(1, 0)), '0));
         end
         send_item(make_item(dcps_pkg::ACTION_APPEND, ch, 1'b1, '1));
         send_item(make_item(dcps_pkg::ACTION_START, ch, 1'b0, '0));
         repeat (MAX_STEPS + 2) send_item(make_item(dcps_pkg::ACTION_TICK, ch, 1'b0, '0));
         send_item(make_item(dcps_pkg::ACTION_APPEND, ch, 1'b0, $urandom));
         send_item(make_item(dcps_pkg::ACTION_CLEAR, ch, 1'b0, '0));
      end
   endtask

   task automatic run_program();
      int first_ch;
      int steps;
      int r;
      bit both;
      first_ch = $urandom_range(1, 0);
      both     = 1'($urandom_range(1, 0));
      if ($urandom_range(3, 0) != 0) begin
         send_item(make_item(dcps_pkg::ACTION_CLEAR, first_ch, 1'($urandom_range(1, 0)),
                             $urandom));
         if (both) send_item(make_item(dcps_pkg::ACTION_CLEAR, 1 - first_ch, 1'b0, $urandom));
      end
      for (int k = 0; k < (both ? 2 : 1); k++) begin
         steps = ($urandom_range(19, 0) == 0) ? $urandom_range(MAX_STEPS + 2, 40)
                                              : $urandom_range(6, 1);
         repeat (steps) begin
            send_item(make_item(dcps_pkg::ACTION_APPEND, k == 0 ? first_ch : 1 - first_ch,
                                1'($urandom_range(1, 0)), random_duration()));
         end
      end
      send_item(make_item(dcps_pkg::ACTION_START, $urandom_range(1, 0),
                          1'($urandom_range(1, 0)), $urandom));
      repeat ($urandom_range(40, 5)) begin
         r = $urandom_range(99, 0);
         if (r < 8) begin
            send_item(make_item(dcps_pkg::ACTION_TOGGLE, $urandom_range(1, 0),
                                1'($urandom_range(1, 0)), $urandom));
         end else if (r < 11) begin
            send_item(make_item(dcps_pkg::ACTION_START, $urandom_range(1, 0), 1'b0,
                                $urandom));
         end else begin
            send_item(make_item(dcps_pkg::ACTION_TICK, $urandom_range(1, 0),
                                1'($urandom_range(1, 0)), $urandom));
         end
      end
   endtask

   task automatic test_random_sequences();
      int target;
      int r;
      target = counted_items + RANDOM_ITEMS;
      wait_for_drain();
      while (counted_items < target) begin
         if ($urandom_range(7, 0) == 0) begin
            gap_mode   = $urandom_range(1, 0);
            stall_mode = $urandom_range(1, 0);
         end
         r = $urandom_range(9, 0);
         if (r < 7) begin
            run_program();
         end else begin
            repeat ($urandom_range(10, 1)) begin
               send_item(make_item(dcps_pkg::ACTION_W'($urandom_range(ACTION_SPARE_LAST,
                                                          dcps_pkg::ACTION_TICK)),
                                   $urandom_range(1, 0), 1'($urandom_range(1, 0)),
                                   random_duration()));
            end
         end
         if ($urandom_range(15, 0) == 0) wait_for_drain();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_actions();
      test_directed_playback();
      test_full_list();
      test_random_sequences();
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* dual_channel_pulse_sequencer.f */
rtl/dcps_pkg.sv
rtl/dual_channel_pulse_sequencer.sv
tb/sv/dual_channel_pulse_sequencer_tb.sv
